>>> rtl/ffra_pkg.sv
package ffra_pkg;
  localparam int MaxExtents = 64;
  localparam int OffsetBits = 32;
  localparam int IdxBits = $clog2(MaxExtents);
  localparam int CntBits = $clog2(MaxExtents + 1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdInit    = 2'd0;
  localparam cmd_t CmdQuery   = 2'd1;
  localparam cmd_t CmdAlloc   = 2'd2;
  localparam cmd_t CmdRelease = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t StatOk      = 2'd0;
  localparam status_t StatNoFit   = 2'd1;
  localparam status_t StatTblFull = 2'd2;

  typedef logic [OffsetBits-1:0] val_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_size;
    logic [31:0] release_offset;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [1:0]  status;
    logic [31:0] alloc_offset;
    logic [31:0] free_total;
    logic [6:0]  extent_count;
  } rsp_t;
endpackage

>>> rtl/ffra_if.sv
interface ffra_req_if;
  import ffra_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ffra_rsp_if;
  import ffra_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ffra_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/first_fit_range_allocator_core.sv
// First-fit free-extent allocator.
// Channels: req_if (command, request_size, release_offset) is taken when
// valid and ready are high; rsp_if carries one result per request; cfg_if
// writes pool_capacity and must only be used while the block is idle.
// The free table lives in a two-array memory (start, length) read one entry
// at a time through a registered read port; a comparator/adder walks it.
// Per request: init restarts the table from the capacity; query/allocate
// scan the extents in order, and an allocate that empties an extent shifts
// the following entries down; release scans to the insert point and then
// shifts the tail up or down, one moved entry at a time. Each moved entry
// is read through the read port and then written back through the write
// port. One request is in flight at a time; ready is low meanwhile.
// The result sits in an output register; while the receiver stalls it is
// held and no new request is taken.
// Reset empties the table (extent count 0, free sum 0, capacity 0); the
// memory contents are not cleared since only live entries are ever read.
module first_fit_range_allocator_core (
  input logic clk_i,
  input logic rst_ni,
  ffra_req_if.sink   req_if,
  ffra_rsp_if.source rsp_if,
  ffra_cfg_if.sink   cfg_if
);
  import ffra_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SScanRd = 4'd1;
  localparam logic [3:0] SScan   = 4'd2;
  localparam logic [3:0] SDnRd   = 4'd3;
  localparam logic [3:0] SDnWr   = 4'd4;
  localparam logic [3:0] SUpRd   = 4'd5;
  localparam logic [3:0] SUpWr   = 4'd6;
  localparam logic [3:0] SRelDec = 4'd7;
  localparam logic [3:0] SDone   = 4'd10;

  logic [3:0] state_q, state_d;
  val_t mem_start [MaxExtents];
  val_t mem_len   [MaxExtents];
  val_t rd_start_q, rd_len_q;
  logic [IdxBits-1:0] rd_addr;
  logic rd_en;
  logic we;
  logic [IdxBits-1:0] wr_addr;
  val_t wr_start, wr_len;

  logic [CntBits-1:0] live_q, live_d;
  val_t sum_q, sum_d;
  logic [31:0] cap_q;
  req_t req_q, req_d;
  logic [CntBits-1:0] idx_q, idx_d;   // scan / shift pointer
  logic [CntBits-1:0] at_q, at_d;     // target entry
  val_t prv_s_q, prv_s_d, prv_l_q, prv_l_d; // entry at-1 for release
  val_t cur_s_q, cur_s_d, cur_l_q, cur_l_d; // entry at
  logic rsp_v_q;
  rsp_t rsp_q, rsp_d;
  logic fin;
  logic ok_d;
  status_t st_d;
  val_t grant_d;
  logic [OffsetBits:0] s1, s2;
  logic lft, rgt;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    if (rd_en) begin
      rd_start_q <= mem_start[rd_addr];
      rd_len_q   <= mem_len[rd_addr];
    end
  end

  assign req_if.ready = (state_q == SIdle) && !rsp_v_q;
  assign cfg_if.ready = 1'b1;
  assign rsp_if.valid = rsp_v_q;
  assign rsp_if.payload = rsp_q;

  val_t rsize, roff;
  assign rsize = req_q.request_size[OffsetBits-1:0];
  assign roff  = req_q.release_offset[OffsetBits-1:0];

  always_comb begin
    state_d = state_q; live_d = live_q; sum_d = sum_q; req_d = req_q;
    idx_d = idx_q; at_d = at_q;
    prv_s_d = prv_s_q; prv_l_d = prv_l_q; cur_s_d = cur_s_q; cur_l_d = cur_l_q;
    rd_en = 1'b0; rd_addr = idx_q[IdxBits-1:0];
    we = 1'b0; wr_addr = '0; wr_start = '0; wr_len = '0;
    fin = 1'b0; ok_d = 1'b1; st_d = StatOk; grant_d = '0;
    s1 = '0; s2 = '0; lft = 1'b0; rgt = 1'b0;
    case (state_q)
      SIdle: begin
        if (req_if.valid && req_if.ready) begin
          req_d = req_if.payload;
          idx_d = '0;
          case (req_if.payload.command)
            CmdInit: begin
              we = 1'b1; wr_addr = '0; wr_start = '0;
              wr_len = cap_q[OffsetBits-1:0];
              live_d = (cap_q != 0) ? CntBits'(1) : '0;
              sum_d = cap_q[OffsetBits-1:0];
              state_d = SDone;
            end
            CmdQuery, CmdAlloc: begin
              if (req_if.payload.request_size == 0) state_d = SDone;
              else state_d = SScanRd;
            end
            default: begin
              if (req_if.payload.request_size[OffsetBits-1:0] == 0) state_d = SDone;
              else state_d = SScanRd;
            end
          endcase
        end
      end
      SScanRd: begin
        if (idx_q == live_q) begin
          if (req_q.command == CmdRelease) begin
            at_d = idx_q; state_d = SRelDec;
          end else begin
            ok_d = 1'b0; st_d = StatNoFit; fin = 1'b1; state_d = SIdle;
          end
        end else begin
          rd_en = 1'b1; state_d = SScan;
        end
      end
      SScan: begin
        if (req_q.command == CmdRelease) begin
          if (rd_start_q < roff) begin
            prv_s_d = rd_start_q; prv_l_d = rd_len_q;
            idx_d = idx_q + 1'b1; state_d = SScanRd;
          end else begin
            cur_s_d = rd_start_q; cur_l_d = rd_len_q;
            at_d = idx_q; state_d = SRelDec;
          end
        end else if ({{(32-OffsetBits+1){1'b0}}, rd_len_q} >=
                     {1'b0, req_q.request_size}) begin
          if (req_q.command == CmdQuery) begin
            fin = 1'b1; state_d = SIdle;
          end else begin
            grant_d = rd_start_q;
            sum_d = sum_q - rsize;
            if (rd_len_q == rsize) begin
              live_d = live_q - 1'b1;
              state_d = SDnRd; idx_d = idx_q + 1'b1;
              fin = 1'b1;
            end else begin
              we = 1'b1; wr_addr = idx_q[IdxBits-1:0];
              wr_start = rd_start_q + rsize; wr_len = rd_len_q - rsize;
              fin = 1'b1; state_d = SIdle;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1; state_d = SScanRd;
        end
      end
      SRelDec: begin
        rgt = (at_q < live_q) && (cur_s_q >= roff) && (cur_s_q - roff == rsize);
        s1 = {1'b0, rsize} + {1'b0, cur_l_q};
        rgt = rgt && !s1[OffsetBits];
        lft = (at_q != 0) && (roff >= prv_s_q) && (roff - prv_s_q == prv_l_q);
        s2 = {1'b0, prv_l_q} + {1'b0, rsize};
        lft = lft && !s2[OffsetBits];
        if (lft && rgt) begin
          s2 = {1'b0, prv_l_q} + {1'b0, s1[OffsetBits-1:0]};
          if (s2[OffsetBits]) rgt = 1'b0;
        end
        s1 = {1'b0, sum_q} + {1'b0, rsize};
        sum_d = s1[OffsetBits] ? '1 : s1[OffsetBits-1:0];
        if (lft && rgt) begin
          we = 1'b1; wr_addr = IdxBits'(at_q - 1'b1);
          wr_start = prv_s_q; wr_len = prv_l_q + rsize + cur_l_q;
          live_d = live_q - 1'b1;
          idx_d = at_q + 1'b1; fin = 1'b1; state_d = SDnRd;
        end else if (lft) begin
          we = 1'b1; wr_addr = IdxBits'(at_q - 1'b1);
          wr_start = prv_s_q; wr_len = prv_l_q + rsize;
          fin = 1'b1; state_d = SIdle;
        end else if (rgt) begin
          we = 1'b1; wr_addr = at_q[IdxBits-1:0];
          wr_start = roff; wr_len = cur_l_q + rsize;
          fin = 1'b1; state_d = SIdle;
        end else if (live_q >= CntBits'(MaxExtents)) begin
          sum_d = sum_q; ok_d = 1'b0; st_d = StatTblFull;
          fin = 1'b1; state_d = SIdle;
        end else begin
          idx_d = live_q; state_d = SUpRd;
        end
      end
      SUpRd: begin
        if (idx_q == at_q) begin
          we = 1'b1; wr_addr = at_q[IdxBits-1:0];
          wr_start = roff; wr_len = rsize;
          live_d = live_q + 1'b1;
          fin = 1'b1; state_d = SIdle;
        end else begin
          rd_en = 1'b1; rd_addr = IdxBits'(idx_q - 1'b1); state_d = SUpWr;
        end
      end
      SUpWr: begin
        we = 1'b1; wr_addr = idx_q[IdxBits-1:0];
        wr_start = rd_start_q; wr_len = rd_len_q;
        idx_d = idx_q - 1'b1; state_d = SUpRd;
      end
      // shift tail down after removing entry idx-1; live already reduced
      SDnRd: begin
        if (idx_q > live_q) state_d = SIdle;
        else begin
          rd_en = 1'b1; state_d = SDnWr;
        end
      end
      SDnWr: begin
        we = 1'b1; wr_addr = IdxBits'(idx_q - 1'b1);
        wr_start = rd_start_q; wr_len = rd_len_q;
        idx_d = idx_q + 1'b1; state_d = SDnRd;
      end
      SDone: begin
        fin = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    rsp_d.success = ok_d;
    rsp_d.status = st_d;
    rsp_d.alloc_offset = 32'(grant_d);
    rsp_d.free_total = 32'(sum_d);
    rsp_d.extent_count = 7'(live_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      live_q  <= '0;
      sum_q   <= '0;
      cap_q   <= '0;
      rsp_v_q <= 1'b0;
      idx_q   <= '0;
      at_q    <= '0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
      at_q    <= at_d;
      if (cfg_if.valid) cap_q <= cfg_if.data;
      if (fin) rsp_v_q <= 1'b1;
      else if (rsp_if.ready) rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    prv_s_q <= prv_s_d; prv_l_q <= prv_l_d;
    cur_s_q <= cur_s_d; cur_l_q <= cur_l_d;
    if (fin) rsp_q <= rsp_d;
  end
endmodule
